// ----- design/srw_pkg.sv -----
// Shared types and constants of the stall recovery watchdog.
package srw_pkg;

	typedef enum logic [2:0] {
		ST_IDLE        = 3'd0,
		ST_WATCHING    = 3'd1,
		ST_SUSPECT     = 3'd2,
		ST_RECOVERING  = 3'd3,
		ST_COOLDOWN    = 3'd4,
		ST_SURRENDERED = 3'd5
	} watch_t;

	typedef enum logic [1:0] {
		ACT_NONE   = 2'd0,
		ACT_RESUME = 2'd1,
		ACT_NUDGE  = 2'd2,
		ACT_RELOAD = 2'd3
	} act_t;

	typedef enum logic [2:0] {
		SEQ_IDLE,
		SEQ_EVAL,
		SEQ_PRUNE,
		SEQ_DECIDE,
		SEQ_OUT
	} seq_t;

	typedef enum logic {
		RING_IDLE,
		RING_WALK
	} ring_state_t;

	typedef struct packed {
		logic clear;
		logic prune;
		logic push;
	} ring_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} ring_sts_t;

	localparam logic [3:0] CMD_STARTED      = 4'd0;
	localparam logic [3:0] CMD_VIDEO_CHANGE = 4'd1;
	localparam logic [3:0] CMD_DISABLED     = 4'd2;
	localparam logic [3:0] CMD_SCRUB        = 4'd3;
	localparam logic [3:0] CMD_PAUSE        = 4'd4;
	localparam logic [3:0] CMD_PROGRESS     = 4'd5;
	localparam logic [3:0] CMD_ERROR        = 4'd6;
	localparam logic [3:0] CMD_SERVER_STOP  = 4'd7;
	localparam logic [3:0] CMD_STALLED      = 4'd8;
	localparam logic [3:0] CMD_TIMER_FIRED  = 4'd9;

	localparam logic [2:0] REG_ATTEMPT_WINDOW = 3'd0;
	localparam logic [2:0] REG_MAX_ATTEMPTS   = 3'd1;
	localparam logic [2:0] REG_CONFIRM_DELAY  = 3'd2;
	localparam logic [2:0] REG_FIRST_BACKOFF  = 3'd3;
	localparam logic [2:0] REG_SECOND_BACKOFF = 3'd4;
	localparam logic [2:0] REG_THIRD_BACKOFF  = 3'd5;
	localparam logic [2:0] REG_COOLDOWN       = 3'd6;
	localparam logic [2:0] REG_PROGRESS_MIN   = 3'd7;

	localparam logic [31:0] POS_UNKNOWN = 32'hFFFF_FFFF;

endpackage

// ----- design/srw_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module srw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [0:DEPTH-1];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ----- design/srw_ring.sv -----
// Attempt stamp ring: RAM, head and count, prune walk and stamp push.
module srw_ring #(
	parameter int ATTEMPT_SLOTS = 8,
	localparam int CW = $clog2(ATTEMPT_SLOTS + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  srw_pkg::ring_req_t req,
	input  logic [31:0]       now_ms,
	input  logic [23:0]       window_ms,
	output srw_pkg::ring_sts_t sts,
	output logic [CW-1:0]     count
);
	import srw_pkg::*;

	localparam int IW = (ATTEMPT_SLOTS > 1) ? $clog2(ATTEMPT_SLOTS) : 1;

	function automatic logic [IW-1:0] wrap_add(input logic [IW-1:0] a, input logic [CW-1:0] b);
		logic [CW:0] s;
		s = {{(CW + 1 - IW){1'b0}}, a} + {1'b0, b};
		if (s >= (CW + 1)'(ATTEMPT_SLOTS)) begin
			s = s - (CW + 1)'(ATTEMPT_SLOTS);
		end
		return s[IW-1:0];
	endfunction

	ring_state_t   state_q, state_d;
	logic [IW-1:0] head_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] rd_i_q;
	logic [CW-1:0] kept_q;
	logic          pend_s1;

	logic          we;
	logic [IW-1:0] waddr;
	logic [31:0]   wdata;
	logic [IW-1:0] raddr;
	logic [31:0]   rdata;
	logic [31:0]   age;
	logic          full;
	logic          rd_go;
	logic          keep;
	logic          fin;

	srw_ram #(.WIDTH(32), .DEPTH(ATTEMPT_SLOTS)) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign age  = now_ms - rdata;
	assign full = (count_q == CW'(ATTEMPT_SLOTS));

	always_comb begin
		state_d = state_q;
		we      = 1'b0;
		waddr   = wrap_add(head_q, kept_q);
		wdata   = now_ms;
		raddr   = wrap_add(head_q, rd_i_q);
		rd_go   = 1'b0;
		keep    = 1'b0;
		fin     = 1'b0;
		case (state_q)
			RING_IDLE: begin
				if (req.prune) begin
					state_d = RING_WALK;
				end else if (req.push) begin
					we    = 1'b1;
					waddr = full ? head_q : wrap_add(head_q, count_q);
				end
			end
			RING_WALK: begin
				rd_go = (rd_i_q != count_q);
				keep  = pend_s1 && (age <= {8'd0, window_ms});
				if (keep) begin
					we    = 1'b1;
					wdata = rdata;
				end
				fin = !rd_go && !pend_s1;
				if (fin) begin
					state_d = RING_IDLE;
				end
			end
			default: begin
				state_d = RING_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= RING_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			count_q <= '0;
			rd_i_q  <= '0;
			kept_q  <= '0;
			pend_s1 <= 1'b0;
		end else if (req.clear) begin
			head_q  <= '0;
			count_q <= '0;
		end else if (state_q == RING_IDLE) begin
			rd_i_q  <= '0;
			kept_q  <= '0;
			pend_s1 <= 1'b0;
			if (!req.prune && req.push) begin
				if (full) begin
					head_q <= wrap_add(head_q, CW'(1));
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
		end else begin
			pend_s1 <= rd_go;
			if (rd_go) begin
				rd_i_q <= rd_i_q + CW'(1);
			end
			if (keep) begin
				kept_q <= kept_q + CW'(1);
			end
			if (fin) begin
				count_q <= kept_q;
			end
		end
	end

	assign sts.busy = (state_q == RING_WALK);
	assign sts.done = fin;
	assign count    = count_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(ATTEMPT_SLOTS))
		else $error("ring count exceeds slots");
	a_kept_behind: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == RING_WALK |-> kept_q <= rd_i_q)
		else $error("compaction write overtook read pointer");
	a_push_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.push |-> state_q == RING_IDLE && !req.prune)
		else $error("stamp push during prune walk");
`endif

endmodule

// ----- design/stall_recovery_watchdog.sv -----
// Top level of the stall recovery watchdog: event sequencer, registers, result register.
//
// Input channel: in_valid/in_stall carry one player event (command, now_ms,
// media_position_ms, live_stream). A beat is taken when in_valid is high and
// in_stall low. Output channel: out_valid/out_stall carry one result beat per
// event (action, arm_timer, arm_delay_ms, cancel_timers, watch_state).
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high, write only while no event is in flight.
// Sequence: an event that needs no recovery step goes from the evaluate state
// straight to the output state. A timer event that runs recovery walks the stamp
// ring through the RAM read port, one stored stamp a cycle, in a prune state,
// then passes a decide state before the output state. One event is in work at a
// time; the next beat is taken the cycle after the result moves into the output
// register.
// A stalled result holds in the output register; in_stall stays high while an
// event is in work, including while its result waits for that register to free.
// Reset clears state, counters and configuration registers to their defaults at once; stamp
// RAM contents need no clearing since only counted entries are read.
module stall_recovery_watchdog #(
	parameter int ATTEMPT_SLOTS = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [3:0]  command,
	input  logic [31:0] now_ms,
	input  logic [31:0] media_position_ms,
	input  logic        live_stream,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  action,
	output logic        arm_timer,
	output logic [23:0] arm_delay_ms,
	output logic        cancel_timers,
	output logic [2:0]  watch_state,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [23:0] cfg_data
);
	import srw_pkg::*;

	localparam int CW = $clog2(ATTEMPT_SLOTS + 1);
	localparam int MW = (CW > 4) ? CW : 4;

	logic [23:0] window_q, confirm_q, first_q, second_q, third_q, cooldown_q, pmin_q;
	logic [3:0]  max_att_q;

	seq_t        seq_q, seq_d;
	watch_t      fsm_q;
	logic [31:0] last_pos_q, susp_pos_q;
	logic [1:0]  incident_q;
	logic [3:0]  cmd_q;
	logic [31:0] now_q, pos_q;
	logic        live_q;
	act_t        res_action_q;
	logic        res_arm_q, res_cancel_q;
	logic [23:0] res_delay_q;
	logic        out_valid_q;

	ring_req_t     ring_req;
	ring_sts_t     ring_sts;
	logic [CW-1:0] ring_count;

	watch_t      ev_state;
	logic        ev_enter, ev_clear, ev_set_last, ev_susp_set, ev_recover;
	logic [31:0] ev_last;
	act_t        ev_action;
	logic        ev_arm, ev_cancel;
	logic [23:0] ev_delay;

	logic signed [33:0] pmin_s, adv_diff, prog_diff;
	logic        adv, prog;
	logic        surrender;
	logic [1:0]  inc_new;
	act_t        dec_action;
	logic [23:0] dec_delay;
	logic        out_free;

	srw_ring #(.ATTEMPT_SLOTS(ATTEMPT_SLOTS)) u_ring (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (ring_req),
		.now_ms   (now_q),
		.window_ms(window_q),
		.sts      (ring_sts),
		.count    (ring_count)
	);

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q   <= 24'd60000;
			max_att_q  <= 4'd3;
			confirm_q  <= 24'd2000;
			first_q    <= 24'd1000;
			second_q   <= 24'd3000;
			third_q    <= 24'd8000;
			cooldown_q <= 24'd10000;
			pmin_q     <= 24'd100;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_ATTEMPT_WINDOW: window_q   <= cfg_data;
				REG_MAX_ATTEMPTS:   max_att_q  <= cfg_data[3:0];
				REG_CONFIRM_DELAY:  confirm_q  <= cfg_data;
				REG_FIRST_BACKOFF:  first_q    <= cfg_data;
				REG_SECOND_BACKOFF: second_q   <= cfg_data;
				REG_THIRD_BACKOFF:  third_q    <= cfg_data;
				REG_COOLDOWN:       cooldown_q <= cfg_data;
				REG_PROGRESS_MIN:   pmin_q     <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	assign pmin_s    = $signed({10'd0, pmin_q});
	assign adv_diff  = $signed({{2{pos_q[31]}}, pos_q})
	                 - $signed({{2{last_pos_q[31]}}, last_pos_q});
	assign prog_diff = $signed({{2{last_pos_q[31]}}, last_pos_q})
	                 - $signed({{2{susp_pos_q[31]}}, susp_pos_q});
	assign adv  = last_pos_q[31] || (adv_diff >= pmin_s);
	assign prog = !susp_pos_q[31] && !last_pos_q[31] && (prog_diff >= pmin_s);

	always_comb begin
		ev_state    = fsm_q;
		ev_enter    = 1'b0;
		ev_clear    = 1'b0;
		ev_set_last = 1'b0;
		ev_last     = pos_q;
		ev_susp_set = 1'b0;
		ev_recover  = 1'b0;
		ev_action   = ACT_NONE;
		ev_arm      = 1'b0;
		ev_delay    = 24'd0;
		ev_cancel   = 1'b0;
		case (cmd_q)
			CMD_STARTED: begin
				ev_state    = ST_WATCHING;
				ev_enter    = 1'b1;
				ev_clear    = 1'b1;
				ev_set_last = 1'b1;
				ev_cancel   = 1'b1;
			end
			CMD_VIDEO_CHANGE, CMD_DISABLED: begin
				ev_state    = ST_IDLE;
				ev_enter    = 1'b1;
				ev_clear    = 1'b1;
				ev_set_last = 1'b1;
				ev_last     = POS_UNKNOWN;
				ev_cancel   = 1'b1;
			end
			CMD_SCRUB, CMD_PAUSE: begin
				if (fsm_q != ST_IDLE && fsm_q != ST_SURRENDERED) begin
					ev_state    = ST_WATCHING;
					ev_enter    = 1'b1;
					ev_set_last = 1'b1;
					ev_cancel   = 1'b1;
				end
			end
			CMD_PROGRESS: begin
				ev_set_last = !pos_q[31];
				if (adv && fsm_q == ST_SUSPECT) begin
					ev_state  = ST_WATCHING;
					ev_enter  = 1'b1;
					ev_cancel = 1'b1;
				end else if (adv && fsm_q == ST_RECOVERING) begin
					ev_state  = ST_COOLDOWN;
					ev_enter  = 1'b1;
					ev_cancel = 1'b1;
					ev_arm    = 1'b1;
					ev_delay  = cooldown_q;
				end
			end
			CMD_ERROR, CMD_SERVER_STOP, CMD_STALLED: begin
				if (fsm_q == ST_WATCHING) begin
					ev_state    = ST_SUSPECT;
					ev_susp_set = 1'b1;
					ev_arm      = 1'b1;
					ev_delay    = confirm_q;
				end
			end
			CMD_TIMER_FIRED: begin
				if (fsm_q == ST_COOLDOWN) begin
					ev_state = ST_WATCHING;
					ev_enter = 1'b1;
					ev_clear = 1'b1;
				end else if (fsm_q == ST_SUSPECT && prog) begin
					ev_state  = ST_WATCHING;
					ev_enter  = 1'b1;
					ev_cancel = 1'b1;
				end else if (fsm_q == ST_SUSPECT || fsm_q == ST_RECOVERING) begin
					ev_recover = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign surrender = {{(MW - CW){1'b0}}, ring_count} >= {{(MW - 4){1'b0}}, max_att_q};
	assign inc_new   = (incident_q == 2'd3) ? 2'd3 : incident_q + 2'd1;

	always_comb begin
		case (inc_new)
			2'd2: begin
				dec_action = live_q ? ACT_RELOAD : ACT_NUDGE;
				dec_delay  = second_q;
			end
			2'd3: begin
				dec_action = ACT_RELOAD;
				dec_delay  = third_q;
			end
			default: begin
				dec_action = ACT_RESUME;
				dec_delay  = first_q;
			end
		endcase
	end

	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		seq_d          = seq_q;
		ring_req.clear = 1'b0;
		ring_req.prune = 1'b0;
		ring_req.push  = 1'b0;
		case (seq_q)
			SEQ_IDLE: begin
				if (in_valid) begin
					seq_d = SEQ_EVAL;
				end
			end
			SEQ_EVAL: begin
				ring_req.clear = ev_clear;
				ring_req.prune = ev_recover;
				seq_d          = ev_recover ? SEQ_PRUNE : SEQ_OUT;
			end
			SEQ_PRUNE: begin
				if (ring_sts.done) begin
					seq_d = SEQ_DECIDE;
				end
			end
			SEQ_DECIDE: begin
				ring_req.push = !surrender;
				seq_d         = SEQ_OUT;
			end
			SEQ_OUT: begin
				if (out_free) begin
					seq_d = SEQ_IDLE;
				end
			end
			default: begin
				seq_d = SEQ_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SEQ_IDLE;
		end else begin
			seq_q <= seq_d;
		end
	end

	assign in_stall = (seq_q != SEQ_IDLE);

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_IDLE && in_valid) begin
			cmd_q  <= command;
			now_q  <= now_ms;
			pos_q  <= media_position_ms;
			live_q <= live_stream;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fsm_q      <= ST_IDLE;
			last_pos_q <= POS_UNKNOWN;
			susp_pos_q <= POS_UNKNOWN;
			incident_q <= 2'd0;
		end else if (seq_q == SEQ_EVAL) begin
			fsm_q <= ev_state;
			if (ev_set_last) begin
				last_pos_q <= ev_last;
			end
			if (ev_enter) begin
				incident_q <= 2'd0;
				susp_pos_q <= POS_UNKNOWN;
			end else if (ev_susp_set) begin
				susp_pos_q <= last_pos_q;
			end
		end else if (seq_q == SEQ_DECIDE) begin
			if (surrender) begin
				fsm_q <= ST_SURRENDERED;
			end else begin
				fsm_q      <= ST_RECOVERING;
				incident_q <= inc_new;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_EVAL) begin
			res_action_q <= ev_action;
			res_arm_q    <= ev_arm;
			res_delay_q  <= ev_delay;
			res_cancel_q <= ev_cancel;
		end else if (seq_q == SEQ_DECIDE) begin
			res_action_q <= surrender ? ACT_NONE : dec_action;
			res_arm_q    <= !surrender;
			res_delay_q  <= surrender ? 24'd0 : dec_delay;
			res_cancel_q <= surrender;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_q == SEQ_OUT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == SEQ_OUT && out_free) begin
			action        <= res_action_q;
			arm_timer     <= res_arm_q;
			arm_delay_ms  <= res_delay_q;
			cancel_timers <= res_cancel_q;
			watch_state   <= fsm_q;
		end
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_done_in_prune: assert property (@(posedge clk) disable iff (!arst_n)
		ring_sts.done |-> seq_q == SEQ_PRUNE)
		else $error("ring walk finished outside prune wait");
	a_idle_ring_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		seq_q == SEQ_IDLE |-> !ring_sts.busy)
		else $error("ring busy while no event in work");
	a_delay_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> arm_timer || arm_delay_ms == 24'd0)
		else $error("delay set without timer arm");
	a_surrender_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && watch_state == ST_SURRENDERED |-> action == ACT_NONE)
		else $error("action issued in surrendered state");
`endif

endmodule
